FILE: src/erpc_pkg.sv
// ----------------------------------------------------------------------------
// erpc_pkg
// Shared types, constants and classification functions for the receive
// packet classifier.
// ----------------------------------------------------------------------------
package erpc_pkg;

   localparam int CounterWidth = 32;
   localparam int NumCounters  = 19;
   localparam int ValueWidth   = 32;
   localparam int WideWidth    = (CounterWidth > ValueWidth) ? CounterWidth : ValueWidth;

   localparam int JobDepth = 4;
   localparam int JobPtrW  = $clog2(JobDepth);
   localparam int JobCntW  = $clog2(JobDepth + 1);

   localparam int OutDepth = 2;
   localparam int OutPtrW  = $clog2(OutDepth);
   localparam int OutCntW  = $clog2(OutDepth + 1);

   localparam logic ReqFrame = 1'b0;
   localparam logic ReqRead  = 1'b1;

   localparam logic KindClass = 1'b0;
   localparam logic KindCount = 1'b1;

   localparam logic [15:0] EtArp  = 16'h0806;
   localparam logic [15:0] EtIpv4 = 16'h0800;
   localparam logic [15:0] EtLldp = 16'h88CC;

   localparam logic [7:0] ProtoIcmp = 8'd1;
   localparam logic [7:0] ProtoIgmp = 8'd2;
   localparam logic [7:0] ProtoTcp  = 8'd6;
   localparam logic [7:0] ProtoUdp  = 8'd17;
   localparam logic [7:0] ProtoPim  = 8'd103;

   localparam logic [15:0] PortBootpServer = 16'd67;
   localparam logic [15:0] PortBootpClient = 16'd68;

   localparam logic [6:0] PosEtypeHi = 7'd12;
   localparam logic [6:0] PosEtypeLo = 7'd13;
   localparam logic [6:0] PosIpHdr   = 7'd14;
   localparam logic [6:0] PosProto   = 7'd23;
   localparam logic [6:0] PosUdpBase = 7'd14;
   localparam logic [6:0] PosMax     = 7'd127;
   localparam logic [3:0] MinHdrWords = 4'd5;

   localparam int CntRxTotal     = 0;
   localparam int CntEthArp      = 1;
   localparam int CntEthIp       = 2;
   localparam int CntIpIcmp      = 3;
   localparam int CntIpUdp       = 4;
   localparam int CntUdpCtrl     = 5;
   localparam int CntUdpDhcp     = 6;
   localparam int CntDhcpUnknown = 7;
   localparam int CntUdpUnknown  = 8;
   localparam int CntIpUnknown   = 9;
   localparam int CntIpPim       = 10;
   localparam int CntIpPimDrop   = 11;
   localparam int CntIpIgmp      = 12;
   localparam int CntIpIgmpDrop  = 13;
   localparam int CntIpTcp       = 14;
   localparam int CntIpTcpDrop   = 15;
   localparam int CntEthLldp     = 16;
   localparam int CntEthLldpDrop = 17;
   localparam int CntEthUnknown  = 18;

   typedef enum logic [3:0] {
      ClsArp      = 4'd0,
      ClsIcmp     = 4'd1,
      ClsCtrl     = 4'd2,
      ClsDhcp     = 4'd3,
      ClsDhcpDrop = 4'd4,
      ClsUdpUnk   = 4'd5,
      ClsPim      = 4'd6,
      ClsIgmp     = 4'd7,
      ClsTcp      = 4'd8,
      ClsIpUnk    = 4'd9,
      ClsLldp     = 4'd10,
      ClsEthUnk   = 4'd11,
      ClsError    = 4'd12
   } class_type;

   typedef struct packed {
      logic      kind;
      class_type cls;
      logic [4:0] index;
   } job_type;

   typedef struct packed {
      logic                  kind;
      class_type             cls;
      logic [ValueWidth-1:0] value;
   } rsp_type;

   typedef logic [NumCounters-1:0] mask_type;

   function automatic class_type classify(
      input logic [15:0] etype,
      input logic [7:0]  proto,
      input logic [3:0]  hdr_words,
      input logic [15:0] src_port,
      input logic [15:0] dst_port,
      input logic [15:0] ctrl_port
   );
      class_type c;
      c = ClsEthUnk;
      if (etype == EtArp) begin
         c = ClsArp;
      end else if (etype == EtIpv4) begin
         case (proto)
            ProtoIcmp: c = ClsIcmp;
            ProtoUdp: begin
               if (hdr_words < MinHdrWords) begin
                  c = ClsError;
               end else if (dst_port == ctrl_port) begin
                  c = ClsCtrl;
               end else if (dst_port == PortBootpClient && src_port == PortBootpServer) begin
                  c = ClsDhcp;
               end else if (dst_port == PortBootpServer && src_port == PortBootpClient) begin
                  c = ClsDhcpDrop;
               end else begin
                  c = ClsUdpUnk;
               end
            end
            ProtoPim:  c = ClsPim;
            ProtoIgmp: c = ClsIgmp;
            ProtoTcp:  c = ClsTcp;
            default:   c = ClsIpUnk;
         endcase
      end else if (etype == EtLldp) begin
         c = ClsLldp;
      end
      return c;
   endfunction

   function automatic mask_type bump_mask(input class_type c);
      mask_type m;
      m = '0;
      m[CntRxTotal] = 1'b1;
      case (c)
         ClsArp: m[CntEthArp] = 1'b1;
         ClsIcmp: begin
            m[CntEthIp]  = 1'b1;
            m[CntIpIcmp] = 1'b1;
         end
         ClsCtrl: begin
            m[CntEthIp]   = 1'b1;
            m[CntIpUdp]   = 1'b1;
            m[CntUdpCtrl] = 1'b1;
         end
         ClsDhcp: begin
            m[CntEthIp]   = 1'b1;
            m[CntIpUdp]   = 1'b1;
            m[CntUdpDhcp] = 1'b1;
         end
         ClsDhcpDrop: begin
            m[CntEthIp]       = 1'b1;
            m[CntIpUdp]       = 1'b1;
            m[CntUdpDhcp]     = 1'b1;
            m[CntDhcpUnknown] = 1'b1;
         end
         ClsUdpUnk: begin
            m[CntEthIp]      = 1'b1;
            m[CntIpUdp]      = 1'b1;
            m[CntUdpUnknown] = 1'b1;
         end
         ClsPim: begin
            m[CntEthIp]     = 1'b1;
            m[CntIpPim]     = 1'b1;
            m[CntIpPimDrop] = 1'b1;
         end
         ClsIgmp: begin
            m[CntEthIp]      = 1'b1;
            m[CntIpIgmp]     = 1'b1;
            m[CntIpIgmpDrop] = 1'b1;
         end
         ClsTcp: begin
            m[CntEthIp]     = 1'b1;
            m[CntIpTcp]     = 1'b1;
            m[CntIpTcpDrop] = 1'b1;
         end
         ClsIpUnk: begin
            m[CntEthIp]     = 1'b1;
            m[CntIpUnknown] = 1'b1;
         end
         ClsLldp: begin
            m[CntEthLldp]     = 1'b1;
            m[CntEthLldpDrop] = 1'b1;
         end
         ClsEthUnk: m[CntEthUnknown] = 1'b1;
         ClsError: begin
            m[CntEthIp] = 1'b1;
            m[CntIpUdp] = 1'b1;
         end
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

FILE: src/ethernet_rx_packet_classifier_top.sv
// ----------------------------------------------------------------------------
// ethernet_rx_packet_classifier_top
// Ethernet receive classifier: parses frame bytes, classifies each frame on
// its last byte, keeps wrapping statistics counters readable by index.
//
//   channel  handshake                   payload
//   req      req_push / req_full         req_type, req_data_byte,
//                                        req_last_byte, req_counter_index
//   rsp      rsp_pop / rsp_empty         rsp_result_kind, rsp_frame_class,
//                                        rsp_counter_value
//   csr      csr_write_enable            csr_control_port
//
// One transaction accepted per cycle while req_full is low; the parser
// captures and classifies in the accepting cycle. The job is registered in
// the job queue on acceptance; the counter update moves it into the result
// queue, when that has room, and it then shows on the rsp ports. Synchronous
// reset clears counters, capture state, control port and both queues.
// req_full rises once the two-entry result queue and then the four-entry job
// queue fill while rsp is not popped.
// ----------------------------------------------------------------------------
module ethernet_rx_packet_classifier_top
   import erpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_type,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [4:0]  req_counter_index,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_result_kind,
   output logic [3:0]  rsp_frame_class,
   output logic [31:0] rsp_counter_value,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_control_port
);

   logic    job_push, job_full, job_pop, job_empty;
   job_type job_in, job_out;
   rsp_type rsp_data;

   erpc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_type         (req_type),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .req_counter_index(req_counter_index),
      .csr_write_enable (csr_write_enable),
      .csr_control_port (csr_control_port),
      .job_push         (job_push),
      .job_data         (job_in),
      .job_full         (job_full)
   );

   erpc_job_queue u_job_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_data(job_in),
      .full     (job_full),
      .pop      (job_pop),
      .pop_data (job_out),
      .empty    (job_empty)
   );

   erpc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .job_data (job_out),
      .job_empty(job_empty),
      .job_pop  (job_pop),
      .rsp_data (rsp_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop)
   );

   assign rsp_result_kind   = rsp_data.kind;
   assign rsp_frame_class   = rsp_data.cls;
   assign rsp_counter_value = rsp_data.value;

endmodule

FILE: src/erpc_front.sv
// ----------------------------------------------------------------------------
// erpc_front
// Header parser: captures frame fields byte by byte, classifies on the last
// byte and queues one job per frame or per valid counter read.
// ----------------------------------------------------------------------------
module erpc_front
   import erpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_type,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [4:0]  req_counter_index,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_control_port,
   output logic        job_push,
   output job_type     job_data,
   input  logic        job_full
);

   logic [6:0]  pos_ff, pos_in;
   logic [15:0] etype_ff, etype_in;
   logic [7:0]  proto_ff, proto_in;
   logic [3:0]  hdr_ff, hdr_in;
   logic [15:0] src_ff, src_in;
   logic [15:0] dst_ff, dst_in;
   logic [15:0] ctrl_ff;
   logic [6:0]  base;
   logic        take;
   logic        take_frame;

   assign req_full   = job_full;
   assign take       = req_push & ~job_full;
   assign take_frame = take & (req_type == ReqFrame);
   assign base       = PosUdpBase + {1'b0, hdr_ff, 2'b00};

   always_comb begin
      etype_in = etype_ff;
      proto_in = proto_ff;
      hdr_in   = hdr_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      if (pos_ff == PosEtypeHi) etype_in[15:8] = req_data_byte;
      if (pos_ff == PosEtypeLo) etype_in[7:0]  = req_data_byte;
      if (pos_ff == PosIpHdr)   hdr_in         = req_data_byte[3:0];
      if (pos_ff == PosProto)   proto_in       = req_data_byte;
      if (hdr_ff >= MinHdrWords) begin
         if (pos_ff == base)         src_in[15:8] = req_data_byte;
         if (pos_ff == base + 7'd1)  src_in[7:0]  = req_data_byte;
         if (pos_ff == base + 7'd2)  dst_in[15:8] = req_data_byte;
         if (pos_ff == base + 7'd3)  dst_in[7:0]  = req_data_byte;
      end
      pos_in = (pos_ff == PosMax) ? pos_ff : pos_ff + 7'd1;
   end

   always_comb begin
      job_push       = 1'b0;
      job_data.kind  = KindClass;
      job_data.cls   = classify(etype_in, proto_in, hdr_in, src_in, dst_in, ctrl_ff);
      job_data.index = req_counter_index;
      if (take) begin
         case (req_type)
            ReqFrame: job_push = req_last_byte;
            ReqRead: begin
               job_push      = (req_counter_index < 5'(NumCounters));
               job_data.kind = KindCount;
               job_data.cls  = ClsArp;
            end
            default: job_push = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         etype_ff <= '0;
         proto_ff <= '0;
         hdr_ff   <= '0;
         src_ff   <= '0;
         dst_ff   <= '0;
         ctrl_ff  <= '0;
      end else begin
         if (csr_write_enable) ctrl_ff <= csr_control_port;
         if (take_frame) begin
            if (req_last_byte) begin
               pos_ff   <= '0;
               etype_ff <= '0;
               proto_ff <= '0;
               hdr_ff   <= '0;
               src_ff   <= '0;
               dst_ff   <= '0;
            end else begin
               pos_ff   <= pos_in;
               etype_ff <= etype_in;
               proto_ff <= proto_in;
               hdr_ff   <= hdr_in;
               src_ff   <= src_in;
               dst_ff   <= dst_in;
            end
         end
      end
   end

endmodule

FILE: src/erpc_job_queue.sv
// ----------------------------------------------------------------------------
// erpc_job_queue
// Short job queue between the parser and the counter back end.
// ----------------------------------------------------------------------------
module erpc_job_queue
   import erpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type pop_data,
   output logic    empty
);

   job_type              slot_ff [JobDepth];
   logic [JobPtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [JobCntW-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == JobCntW'(JobDepth));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push & ~do_pop) count_in = count_ff + JobCntW'(1);
      if (do_pop & ~do_push) count_in = count_ff - JobCntW'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + JobPtrW'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + JobPtrW'(1);
         count_ff <= count_in;
      end
   end

   a_job_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("job pushed into full queue");

   a_job_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= JobCntW'(JobDepth))
      else $error("job queue count out of range");

endmodule

FILE: src/erpc_back.sv
// ----------------------------------------------------------------------------
// erpc_back
// Statistics counters and result queue: carries out classification and
// counter read jobs in order.
// ----------------------------------------------------------------------------
module erpc_back
   import erpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  job_type job_data,
   input  logic    job_empty,
   output logic    job_pop,
   output rsp_type rsp_data,
   output logic    rsp_empty,
   input  logic    rsp_pop
);

   logic [CounterWidth-1:0] cnt_ff [NumCounters];
   rsp_type                 out_ff [OutDepth];
   logic [OutPtrW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [OutCntW-1:0]      count_ff, count_in;
   logic                    out_full;
   logic                    do_rsp_pop;
   logic [WideWidth-1:0]    wide;
   rsp_type                 result;
   mask_type                bump;

   assign out_full   = (count_ff == OutCntW'(OutDepth));
   assign rsp_empty  = (count_ff == '0);
   assign do_rsp_pop = rsp_pop & ~rsp_empty;
   assign job_pop    = ~job_empty & ~out_full;
   assign rsp_data   = out_ff[rd_ptr_ff];
   assign wide       = WideWidth'(cnt_ff[job_data.index]);

   always_comb begin
      result.kind  = job_data.kind;
      result.cls   = job_data.cls;
      result.value = '0;
      bump         = '0;
      case (job_data.kind)
         KindClass: bump = bump_mask(job_data.cls);
         KindCount: begin
            result.cls   = ClsArp;
            result.value = wide[ValueWidth-1:0];
         end
         default: bump = '0;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (job_pop & ~do_rsp_pop) count_in = count_ff + OutCntW'(1);
      if (do_rsp_pop & ~job_pop) count_in = count_ff - OutCntW'(1);
   end

   always_ff @(posedge clock) begin
      if (job_pop) out_ff[wr_ptr_ff] <= result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumCounters; i++) cnt_ff[i] <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (job_pop) begin
            for (int i = 0; i < NumCounters; i++) begin
               if (bump[i]) cnt_ff[i] <= cnt_ff[i] + CounterWidth'(1);
            end
            wr_ptr_ff <= wr_ptr_ff + OutPtrW'(1);
         end
         if (do_rsp_pop) rd_ptr_ff <= rd_ptr_ff + OutPtrW'(1);
         count_ff <= count_in;
      end
   end

   a_rsp_after_job: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> count_ff != '0)
      else $error("job taken but no transaction queued");

   a_rsp_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= OutCntW'(OutDepth))
      else $error("result queue count out of range");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      (job_pop && job_data.kind == KindCount) |-> job_data.index < 5'(NumCounters))
      else $error("counter read index out of range");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the receive packet classifier. A directed table of
// frames and counter reads is followed by random frames across several control
// port settings. A predictor tracks frame capture, classification and the
// statistics counters, and every popped transaction is checked against it.
// ----------------------------------------------------------------------------
module testbench;
   import erpc_pkg::*;

   localparam logic [15:0] CtrlDirected      = 16'h1234;
   localparam logic [4:0]  BadIndexLow       = 5'd19;
   localparam logic [4:0]  BadIndexTop       = 5'd31;
   localparam int          DrainCycles       = 6;
   localparam int          ItemsPerStep      = 130;
   localparam int          MinResultsPerStep = 15;
   localparam int          LongHoldCycles    = 400;
   localparam int          GaplessItems      = 100;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic       last;
      logic [4:0] index;
   } rx_item_type;

   typedef struct {
      logic        is_read;
      logic [4:0]  index;
      logic [15:0] etype;
      logic [7:0]  hdr;
      logic [7:0]  proto;
      logic [15:0] src;
      logic [15:0] dst;
      int          len;
      int          mid_at;
      logic        typed;
      logic        has;
      class_type   cls;
      logic [31:0] value;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic        req_type;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic [4:0]  req_counter_index;
   logic        rsp_empty;
   logic        rsp_pop;
   logic        rsp_result_kind;
   logic [3:0]  rsp_frame_class;
   logic [31:0] rsp_counter_value;
   logic        csr_write_enable;
   logic [15:0] csr_control_port;

   // predictor state
   logic [6:0]              rx_pos;
   logic [15:0]             rx_etype;
   logic [7:0]              rx_proto;
   logic [3:0]              rx_hdr_words;
   logic [15:0]             rx_src_port;
   logic [15:0]             rx_dst_port;
   logic [CounterWidth-1:0] stat_count [NumCounters];
   logic [15:0]             ctrl_port_model;

   rsp_type     pending_results [$];
   logic [7:0]  frame_bytes [$];
   dir_row_type rows [$];

   logic    typed_armed;
   logic    typed_has;
   rsp_type typed_result;

   int items_accepted;
   int results_expected;
   int failures;
   int hold_request;
   int burst_left;
   bit gapless;

   ethernet_rx_packet_classifier_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_type          (req_type),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .req_counter_index (req_counter_index),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_frame_class   (rsp_frame_class),
      .rsp_counter_value (rsp_counter_value),
      .csr_write_enable  (csr_write_enable),
      .csr_control_port  (csr_control_port)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

   function automatic void clear_capture();
      rx_pos       = '0;
      rx_etype     = '0;
      rx_proto     = '0;
      rx_hdr_words = '0;
      rx_src_port  = '0;
      rx_dst_port  = '0;
   endfunction

   function automatic void count_up(input int idx);
      stat_count[idx] = stat_count[idx] + 1'b1;
   endfunction

   function automatic class_type classify_frame();
      class_type verdict;
      count_up(CntRxTotal);
      if (rx_etype == EtArp) begin
         count_up(CntEthArp);
         verdict = ClsArp;
      end else if (rx_etype == EtIpv4) begin
         count_up(CntEthIp);
         case (rx_proto)
            ProtoIcmp: begin
               count_up(CntIpIcmp);
               verdict = ClsIcmp;
            end
            ProtoUdp: begin
               count_up(CntIpUdp);
               if (rx_hdr_words < MinHdrWords) begin
                  verdict = ClsError;
               end else if (rx_dst_port == ctrl_port_model) begin
                  count_up(CntUdpCtrl);
                  verdict = ClsCtrl;
               end else if (rx_dst_port == PortBootpClient && rx_src_port == PortBootpServer) begin
                  count_up(CntUdpDhcp);
                  verdict = ClsDhcp;
               end else if (rx_dst_port == PortBootpServer && rx_src_port == PortBootpClient) begin
                  count_up(CntDhcpUnknown);
                  count_up(CntUdpDhcp);
                  verdict = ClsDhcpDrop;
               end else begin
                  count_up(CntUdpUnknown);
                  verdict = ClsUdpUnk;
               end
            end
            ProtoPim: begin
               count_up(CntIpPim);
               count_up(CntIpPimDrop);
               verdict = ClsPim;
            end
            ProtoIgmp: begin
               count_up(CntIpIgmp);
               count_up(CntIpIgmpDrop);
               verdict = ClsIgmp;
            end
            ProtoTcp: begin
               count_up(CntIpTcp);
               count_up(CntIpTcpDrop);
               verdict = ClsTcp;
            end
            default: begin
               count_up(CntIpUnknown);
               verdict = ClsIpUnk;
            end
         endcase
      end else if (rx_etype == EtLldp) begin
         count_up(CntEthLldp);
         count_up(CntEthLldpDrop);
         verdict = ClsLldp;
      end else begin
         count_up(CntEthUnknown);
         verdict = ClsEthUnk;
      end
      return verdict;
   endfunction

   // advance the predictor by one accepted transaction
   function automatic void accept(input rx_item_type it);
      logic    has;
      rsp_type res;
      int      base;
      has = 1'b0;
      res = '0;
      if (it.kind == ReqRead) begin
         if (int'(it.index) < NumCounters) begin
            has       = 1'b1;
            res.kind  = KindCount;
            res.cls   = ClsArp;
            res.value = stat_count[it.index][31:0];
         end
      end else begin
         if (rx_pos == PosEtypeHi) rx_etype[15:8] = it.data;
         if (rx_pos == PosEtypeLo) rx_etype[7:0] = it.data;
         if (rx_pos == PosIpHdr) rx_hdr_words = it.data[3:0];
         if (rx_pos == PosProto) rx_proto = it.data;
         if (rx_hdr_words >= MinHdrWords) begin
            base = int'(PosUdpBase) + 4 * int'(rx_hdr_words);
            if (int'(rx_pos) == base) rx_src_port[15:8] = it.data;
            if (int'(rx_pos) == base + 1) rx_src_port[7:0] = it.data;
            if (int'(rx_pos) == base + 2) rx_dst_port[15:8] = it.data;
            if (int'(rx_pos) == base + 3) rx_dst_port[7:0] = it.data;
         end
         if (rx_pos != PosMax) rx_pos = rx_pos + 1'b1;
         if (it.last) begin
            has       = 1'b1;
            res.kind  = KindClass;
            res.cls   = classify_frame();
            res.value = '0;
            clear_capture();
         end
      end
      if (typed_armed) begin
         has         = typed_has;
         res         = typed_result;
         typed_armed = 1'b0;
      end
      if (has) begin
         pending_results.push_back(res);
         results_expected++;
      end
      items_accepted++;
   endfunction

   function automatic void check_result();
      rsp_type exp_rsp;
      if (pending_results.size() == 0) begin
         $error("unexpected transaction: kind %0d class %0d value %0d",
                rsp_result_kind, rsp_frame_class, rsp_counter_value);
         failures++;
      end else begin
         exp_rsp = pending_results.pop_front();
         if (rsp_result_kind !== exp_rsp.kind) begin
            $error("rsp_result_kind expected %0d got %0d", exp_rsp.kind, rsp_result_kind);
            failures++;
         end
         if (rsp_frame_class !== exp_rsp.cls) begin
            $error("rsp_frame_class expected %0d got %0d", exp_rsp.cls, rsp_frame_class);
            failures++;
         end
         if (rsp_counter_value !== exp_rsp.value) begin
            $error("rsp_counter_value expected %0d got %0d", exp_rsp.value, rsp_counter_value);
            failures++;
         end
      end
   endfunction

   function automatic void put_byte(input int pos, input logic [7:0] v);
      if (pos < frame_bytes.size()) frame_bytes[pos] = v;
   endfunction

   function automatic void build_frame(input logic [15:0] etype, input logic [7:0] hdr,
                                       input logic [7:0] proto, input logic [15:0] src,
                                       input logic [15:0] dst, input int len);
      int base;
      frame_bytes.delete();
      for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom));
      put_byte(PosEtypeHi, etype[15:8]);
      put_byte(PosEtypeLo, etype[7:0]);
      put_byte(PosIpHdr, hdr);
      put_byte(PosProto, proto);
      if (hdr[3:0] >= MinHdrWords) begin
         base = int'(PosUdpBase) + 4 * int'(hdr[3:0]);
         put_byte(base, src[15:8]);
         put_byte(base + 1, src[7:0]);
         put_byte(base + 2, dst[15:8]);
         put_byte(base + 3, dst[7:0]);
      end
   endfunction

   function automatic logic [15:0] random_port();
      case ($urandom_range(0, 3))
         0: return ctrl_port_model;
         1: return PortBootpServer;
         2: return PortBootpClient;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [4:0] random_index();
      if ($urandom_range(0, 99) < 85) return 5'($urandom_range(0, NumCounters - 1));
      return 5'($urandom_range(NumCounters, 31));
   endfunction

   function automatic void make_random_frame(output int mid_at);
      logic [15:0] etype;
      logic [7:0]  hdr;
      logic [7:0]  proto;
      int          r;
      int          needed;
      int          len;
      r = $urandom_range(0, 99);
      if (r < 10) etype = EtArp;
      else if (r < 75) etype = EtIpv4;
      else if (r < 83) etype = EtLldp;
      else etype = 16'($urandom);
      hdr[7:4] = 4'($urandom);
      r = $urandom_range(0, 99);
      if (r < 45) hdr[3:0] = MinHdrWords;
      else if (r < 85) hdr[3:0] = 4'($urandom_range(6, 15));
      else hdr[3:0] = 4'($urandom_range(0, 4));
      case ($urandom_range(0, 9))
         0: proto = ProtoIcmp;
         1: proto = ProtoPim;
         2: proto = ProtoIgmp;
         3: proto = ProtoTcp;
         4: proto = 8'($urandom);
         default: proto = ProtoUdp;
      endcase
      needed = (hdr[3:0] >= MinHdrWords) ? int'(PosUdpBase) + 4 * int'(hdr[3:0]) + 4
                                         : int'(PosProto) + 1;
      r = $urandom_range(0, 99);
      if (r < 75) len = needed + $urandom_range(0, 8);
      else if (r < 92) len = $urandom_range(1, needed - 1);
      else len = $urandom_range(128, 160);
      build_frame(etype, hdr, proto, random_port(), random_port(), len);
      mid_at = ($urandom_range(0, 99) < 20) ? $urandom_range(0, len - 1) : -1;
   endfunction

   // sender sends in bursts with random idle gaps between them, unless gapless
   task automatic pace();
      int gap;
      if (!gapless) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge clock);
            req_push <= 1'b0;
            repeat (gap - 1) @(negedge clock);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 24);
         end
         burst_left--;
      end
   endtask

   task automatic send_item(input rx_item_type it);
      pace();
      @(negedge clock);
      req_push          <= 1'b1;
      req_type          <= it.kind;
      req_data_byte     <= it.data;
      req_last_byte     <= it.last;
      req_counter_index <= it.index;
      @(posedge clock);
      while (req_full) @(posedge clock);
      accept(it);
   endtask

   task automatic send_read(input logic [4:0] idx);
      send_item('{ReqRead, 8'($urandom), 1'($urandom), idx});
   endtask

   task automatic send_frame(input int mid_at, input logic typed, input rsp_type typed_rsp);
      int n;
      n = frame_bytes.size();
      for (int i = 0; i < n; i++) begin
         if (i == mid_at) send_read(5'($urandom_range(0, NumCounters - 1)));
         if (typed && i == n - 1) begin
            typed_armed  = 1'b1;
            typed_has    = 1'b1;
            typed_result = typed_rsp;
         end
         send_item('{ReqFrame, frame_bytes[i], 1'(i == n - 1), 5'($urandom)});
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_control_port(input logic [15:0] v);
      wait_idle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_control_port <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      ctrl_port_model = v;
   endtask

   function automatic dir_row_type frame_row(input logic [15:0] etype, input logic [7:0] hdr,
                                             input logic [7:0] proto, input logic [15:0] src,
                                             input logic [15:0] dst, input int len,
                                             input int mid_at, input logic typed,
                                             input class_type cls);
      dir_row_type row;
      row = '{1'b0, '0, etype, hdr, proto, src, dst, len, mid_at, typed, 1'b1, cls, '0};
      return row;
   endfunction

   function automatic dir_row_type read_row(input logic [4:0] idx, input logic typed,
                                            input logic has, input logic [31:0] value);
      dir_row_type row;
      row = '{1'b1, idx, '0, '0, '0, '0, '0, 0, -1, typed, has, ClsArp, value};
      return row;
   endfunction

   // receiver: stall patterns plus a single long hold
   initial begin : rsp_side
      int          stall_left;
      int          mode;
      int          mode_left;
      int          bit_pos;
      logic [31:0] pattern;
      stall_left = 0;
      mode       = 0;
      mode_left  = 0;
      bit_pos    = 0;
      pattern    = '1;
      rsp_pop    = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) check_result();
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 120);
            pattern   = $urandom;
         end
         mode_left--;
         bit_pos = (bit_pos + 1) % 32;
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else begin
            case (mode)
               0: rsp_pop <= 1'b1;
               1: rsp_pop <= pattern[bit_pos];
               default: rsp_pop <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      logic [15:0] step_ports [5];
      logic [15:0] port;
      int          start_items;
      int          start_results;
      int          mid_at;
      reset             = 1'b1;
      req_push          = 1'b0;
      req_type          = ReqFrame;
      req_data_byte     = '0;
      req_last_byte     = 1'b0;
      req_counter_index = '0;
      csr_write_enable  = 1'b0;
      csr_control_port  = '0;
      ctrl_port_model   = '0;
      for (int i = 0; i < NumCounters; i++) stat_count[i] = '0;
      clear_capture();
      typed_armed       = 1'b0;
      typed_has         = 1'b0;
      typed_result      = '0;
      items_accepted    = 0;
      results_expected  = 0;
      failures          = 0;
      hold_request      = 0;
      burst_left        = 0;
      gapless           = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_control_port(CtrlDirected);

      rows.push_back(read_row(CntRxTotal, 1, 1, 32'd0));
      rows.push_back(read_row(CntEthUnknown, 1, 1, 32'd0));
      rows.push_back(read_row(BadIndexTop, 1, 0, 32'd0));
      rows.push_back(read_row(BadIndexLow, 1, 0, 32'd0));
      rows.push_back(frame_row(EtArp, 8'h45, ProtoUdp, 16'h0, 16'h0, 42, -1, 1, ClsArp));
      rows.push_back(frame_row(EtIpv4, 8'h45, ProtoIcmp, 16'h0, 16'h0, 42, -1, 1, ClsIcmp));
      rows.push_back(frame_row(EtIpv4, 8'h45, ProtoUdp, 16'h9999, CtrlDirected, 42, -1, 1,
                               ClsCtrl));
      rows.push_back(frame_row(EtIpv4, 8'h45, ProtoUdp, PortBootpServer, PortBootpClient, 42,
                               -1, 1, ClsDhcp));
      rows.push_back(frame_row(EtIpv4, 8'h45, ProtoUdp, PortBootpClient, PortBootpServer, 42,
                               -1, 1, ClsDhcpDrop));
      rows.push_back(frame_row(EtIpv4, 8'h45, ProtoUdp, 16'hFFFF, 16'h0001, 42, -1, 1,
                               ClsUdpUnk));
      rows.push_back(frame_row(EtIpv4, 8'h45, ProtoPim, 16'h0, 16'h0, 42, -1, 1, ClsPim));
      rows.push_back(frame_row(EtIpv4, 8'h45, ProtoIgmp, 16'h0, 16'h0, 42, -1, 1, ClsIgmp));
      rows.push_back(frame_row(EtIpv4, 8'h45, ProtoTcp, 16'h0, 16'h0, 42, -1, 1, ClsTcp));
      rows.push_back(frame_row(EtIpv4, 8'h45, 8'hFF, 16'h0, 16'h0, 42, -1, 1, ClsIpUnk));
      rows.push_back(frame_row(EtLldp, 8'h00, 8'h00, 16'h0, 16'h0, 30, -1, 1, ClsLldp));
      rows.push_back(frame_row(16'hFFFF, 8'hFF, ProtoUdp, 16'h0, 16'h0, 42, -1, 1, ClsEthUnk));
      rows.push_back(frame_row(EtIpv4, 8'h44, ProtoUdp, 16'h0, CtrlDirected, 42, -1, 1,
                               ClsError));
      rows.push_back(frame_row(EtIpv4, 8'hF0, ProtoUdp, 16'h0, CtrlDirected, 42, -1, 1,
                               ClsError));
      rows.push_back(frame_row(EtIpv4, 8'h44, ProtoTcp, 16'h0, 16'h0, 42, -1, 0, ClsArp));
      rows.push_back(frame_row(EtIpv4, 8'h4F, ProtoUdp, PortBootpServer, CtrlDirected, 80,
                               -1, 0, ClsArp));
      rows.push_back(frame_row(EtArp, 8'h00, 8'h00, 16'h0, 16'h0, 1, -1, 1, ClsEthUnk));
      rows.push_back(frame_row(EtIpv4, 8'h45, ProtoUdp, 16'h0, 16'h0, 14, -1, 1, ClsIpUnk));
      rows.push_back(frame_row(EtIpv4, 8'h45, ProtoUdp, 16'h0, CtrlDirected, 36, -1, 0,
                               ClsArp));
      rows.push_back(frame_row(EtIpv4, 8'h46, ProtoTcp, 16'h0, 16'h0, 150, -1, 0, ClsArp));
      rows.push_back(frame_row(EtIpv4, 8'h45, ProtoUdp, 16'h0, CtrlDirected, 42, 20, 0,
                               ClsArp));
      rows.push_back(read_row(CntIpUdp, 0, 0, 32'd0));
      rows.push_back(read_row(CntRxTotal, 0, 0, 32'd0));

      foreach (rows[i]) begin
         if (rows[i].is_read) begin
            typed_armed  = rows[i].typed;
            typed_has    = rows[i].has;
            typed_result = '{KindCount, ClsArp, rows[i].value};
            send_read(rows[i].index);
         end else begin
            build_frame(rows[i].etype, rows[i].hdr, rows[i].proto, rows[i].src, rows[i].dst,
                        rows[i].len);
            send_frame(rows[i].mid_at, rows[i].typed, '{KindClass, rows[i].cls, 32'd0});
         end
      end

      step_ports = '{16'h0000, 16'hFFFF, PortBootpClient, PortBootpServer, 16'h0000};
      for (int s = 0; s < 5; s++) begin
         port = (s == 4) ? 16'($urandom) : step_ports[s];
         write_control_port(port);
         start_items   = items_accepted;
         start_results = results_expected;
         if (s == 1) begin
            hold_request = LongHoldCycles;
            gapless      = 1'b1;
         end
         while (items_accepted - start_items < ItemsPerStep ||
                results_expected - start_results < MinResultsPerStep) begin
            if (gapless && items_accepted - start_items >= GaplessItems) gapless = 1'b0;
            if ($urandom_range(0, 99) < 20) begin
               send_read(random_index());
            end else begin
               make_random_frame(mid_at);
               send_frame(mid_at, 1'b0, '0);
            end
         end
      end

      wait_idle();
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
